FILE: design/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared constants, codes and controller/datapath types for the postfix
// expression evaluator.
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int MAX_DIGITS  = 4;

  localparam int CHAR_W     = 8;
  localparam int DATA_W     = 32;
  localparam int STATUS_W   = 3;
  localparam int LEN_W      = 8;
  localparam int ACC_W      = $clog2(10 ** MAX_DIGITS);
  localparam int DCNT_W     = $clog2(MAX_DIGITS + 1);
  localparam int STACK_AW   = $clog2(STACK_DEPTH);
  localparam int DEPTH_W    = $clog2(STACK_DEPTH + 1);
  localparam int DIV_CNT_W  = $clog2(DATA_W + 1);

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(100);

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_MUL   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_DIV   = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_MOD   = 8'h25;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_BADCHAR,
    ST_UNDERFLOW,
    ST_DIVZERO,
    ST_COUNT,
    ST_TOOLONG,
    ST_OVERFLOW
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_PUSH,
    S_CLASS,
    S_FETCH_A,
    S_EXEC,
    S_DIV,
    S_WRITE,
    S_END,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic    load_item;
    logic    acc_digit;
    logic    push_num;
    logic    rd_top;
    logic    rd_second;
    logic    lat_b;
    logic    alu_exec;
    logic    div_start;
    logic    div_finish;
    logic    write_res;
    logic    rd_base;
    logic    emit;
    logic    raise_en;
    status_t raise_code;
  } cmd_t;

  typedef struct packed {
    logic err_set;
    logic is_digit;
    logic is_op;
    logic is_div_op;
    logic is_sep;
    logic digits_full;
    logic has_digits;
    logic stack_full;
    logic stack_short;
    logic divisor_zero;
    logic last;
    logic final_bad;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

FILE: design/pfe_if.sv
// ----------------------------------------------------------------------------
// pfe_if
// Valid/ready channels for expression characters and for results.
// ----------------------------------------------------------------------------
interface pfe_in_if import pfe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

interface pfe_out_if import pfe_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [DATA_W-1:0]   value;
  logic        [STATUS_W-1:0] status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

FILE: design/pfe_divider.sv
// ----------------------------------------------------------------------------
// pfe_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfe_divider import pfe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic [DATA_W-1:0] quotient,
  output logic [DATA_W-1:0] remainder,
  output logic              done
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DATA_W-1:0]    dvs;
  logic [DATA_W:0]      rem_sh;
  logic [DATA_W+1:0]    diff;

  assign rem_sh = {remainder, quotient[DATA_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DATA_W);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      // A clear top bit means the shifted remainder covered the divisor.
      if (!diff[DATA_W+1]) begin
        remainder <= diff[DATA_W-1:0];
        quotient  <= {quotient[DATA_W-2:0], 1'b1};
      end else begin
        remainder <= rem_sh[DATA_W-1:0];
        quotient  <= {quotient[DATA_W-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: design/pfe_datapath.sv
// ----------------------------------------------------------------------------
// pfe_datapath
// Operand stack memory, number accumulator, counters, error register,
// arithmetic unit and result register.
// ----------------------------------------------------------------------------
module pfe_datapath import pfe_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output stat_t               stat,
  input  logic [CHAR_W-1:0]   item_char,
  input  logic                item_last,
  input  logic                cfg_wr_en,
  input  logic [LEN_W-1:0]    cfg_wr_data,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [DATA_W-1:0]   out_value,
  output logic [STATUS_W-1:0] out_status
);

  logic [DATA_W-1:0]  mem [STACK_DEPTH];
  logic [DATA_W-1:0]  rd_data;
  logic               mem_we;
  logic [STACK_AW-1:0] waddr;
  logic [DATA_W-1:0]  wdata;
  logic               mem_re;
  logic [STACK_AW-1:0] raddr;

  logic [CHAR_W-1:0]  char_q;
  logic               last_q;
  logic [LEN_W-1:0]   max_len;
  logic [LEN_W-1:0]   char_count;
  logic [DEPTH_W-1:0] depth;
  logic [DEPTH_W-1:0] depth_m1;
  logic [DEPTH_W-1:0] depth_m2;
  logic [ACC_W-1:0]   acc;
  logic [DCNT_W-1:0]  digit_count;
  status_t            err;
  status_t            err_next;

  logic [DATA_W-1:0]  opb;
  logic [DATA_W-1:0]  res;
  logic [DATA_W-1:0]  alu_res;
  logic               neg_a;
  logic               neg_b;
  logic               want_rem;
  logic [DATA_W-1:0]  quo;
  logic [DATA_W-1:0]  rem;
  logic               div_done;
  logic [DATA_W-1:0]  abs_a;
  logic [DATA_W-1:0]  abs_b;
  logic               too_long;

  assign depth_m1 = depth - DEPTH_W'(1);
  assign depth_m2 = depth - DEPTH_W'(2);
  assign too_long = (char_count >= max_len);

  always_comb begin
    stat.err_set      = (err != ST_OK);
    stat.is_digit     = char_q inside {[CH_ZERO:CH_NINE]};
    stat.is_op        = char_q inside {CH_PLUS, CH_MINUS, CH_MUL, CH_DIV, CH_MOD};
    stat.is_div_op    = char_q inside {CH_DIV, CH_MOD};
    stat.is_sep       = char_q inside {CH_SPACE, CH_LF, CH_CR};
    stat.digits_full  = (digit_count >= DCNT_W'(MAX_DIGITS));
    stat.has_digits   = (digit_count != '0);
    stat.stack_full   = (depth >= DEPTH_W'(STACK_DEPTH));
    stat.stack_short  = (depth < DEPTH_W'(2));
    stat.divisor_zero = (opb == '0);
    stat.last         = last_q;
    stat.final_bad    = (digit_count != '0) || (depth != DEPTH_W'(1));
    stat.div_done     = div_done;
    stat.out_free     = !out_valid || out_ready;
  end

  // Stack memory: one write and one registered read per cycle.
  always_comb begin
    mem_we = 1'b0;
    waddr  = depth[STACK_AW-1:0];
    wdata  = DATA_W'(acc);
    if (cmd.push_num && !stat.stack_full) begin
      mem_we = 1'b1;
    end else if (cmd.write_res) begin
      mem_we = 1'b1;
      waddr  = depth_m2[STACK_AW-1:0];
      wdata  = res;
    end
    mem_re = cmd.rd_top || cmd.rd_second || cmd.rd_base;
    if (cmd.rd_top) begin
      raddr = depth_m1[STACK_AW-1:0];
    end else if (cmd.rd_second) begin
      raddr = depth_m2[STACK_AW-1:0];
    end else begin
      raddr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rd_data <= mem[raddr];
    end
  end

  always_comb begin
    err_next = err;
    if (err == ST_OK) begin
      if (cmd.load_item && too_long) begin
        err_next = ST_TOOLONG;
      end else if (cmd.raise_en) begin
        err_next = cmd.raise_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len     <= MAX_LEN_RESET;
      char_count  <= '0;
      depth       <= '0;
      acc         <= '0;
      digit_count <= '0;
      err         <= ST_OK;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_len <= cfg_wr_data;
      end
      err <= err_next;
      if (cmd.load_item && !too_long) begin
        char_count <= char_count + LEN_W'(1);
      end
      if (cmd.acc_digit) begin
        acc         <= acc * ACC_W'(10) + ACC_W'(char_q[3:0]);
        digit_count <= digit_count + DCNT_W'(1);
      end
      if (cmd.push_num) begin
        acc         <= '0;
        digit_count <= '0;
        if (!stat.stack_full) begin
          depth <= depth + DEPTH_W'(1);
        end
      end
      // Two operands popped and one pushed.
      if (cmd.write_res) begin
        depth <= depth_m1;
      end
      if (cmd.emit) begin
        out_valid   <= 1'b1;
        char_count  <= '0;
        depth       <= '0;
        acc         <= '0;
        digit_count <= '0;
        err         <= ST_OK;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    case (char_q)
      CH_PLUS:  alu_res = rd_data + opb;
      CH_MINUS: alu_res = rd_data - opb;
      default:  alu_res = rd_data * opb;
    endcase
  end

  assign abs_a = rd_data[DATA_W-1] ? (DATA_W'(0) - rd_data) : rd_data;
  assign abs_b = opb[DATA_W-1] ? (DATA_W'(0) - opb) : opb;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      char_q <= item_char;
      last_q <= item_last;
    end
    if (cmd.lat_b) begin
      opb <= rd_data;
    end
    if (cmd.alu_exec) begin
      res <= alu_res;
    end
    if (cmd.div_start) begin
      neg_a    <= rd_data[DATA_W-1];
      neg_b    <= opb[DATA_W-1];
      want_rem <= (char_q == CH_MOD);
    end
    // The remainder follows the dividend's sign, the quotient the sign product.
    if (cmd.div_finish) begin
      if (want_rem) begin
        res <= neg_a ? (DATA_W'(0) - rem) : rem;
      end else begin
        res <= (neg_a != neg_b) ? (DATA_W'(0) - quo) : quo;
      end
    end
    if (cmd.emit) begin
      out_value  <= (err == ST_OK) ? rd_data : '0;
      out_status <= err;
    end
  end

  pfe_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (abs_a),
    .divisor   (abs_b),
    .quotient  (quo),
    .remainder (rem),
    .done      (div_done)
  );

endmodule

FILE: design/pfe_ctrl.sv
// ----------------------------------------------------------------------------
// pfe_ctrl
// Sequencer that steps each character through decode, number push,
// operator fetch, execute, write-back and end-of-expression handling.
// ----------------------------------------------------------------------------
module pfe_ctrl import pfe_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.raise_code = ST_OK;
    item_ready     = 1'b0;
    case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.err_set) begin
          state_next = S_END;
        end else if (stat.is_digit) begin
          if (stat.digits_full) begin
            cmd.raise_en   = 1'b1;
            cmd.raise_code = ST_OVERFLOW;
          end else begin
            cmd.acc_digit = 1'b1;
          end
          state_next = S_END;
        end else if (stat.has_digits) begin
          state_next = S_PUSH;
        end else begin
          state_next = S_CLASS;
        end
      end
      S_PUSH: begin
        cmd.push_num = 1'b1;
        if (stat.stack_full) begin
          cmd.raise_en   = 1'b1;
          cmd.raise_code = ST_OVERFLOW;
        end
        state_next = S_CLASS;
      end
      S_CLASS: begin
        if (stat.err_set) begin
          state_next = S_END;
        end else if (stat.is_op) begin
          if (stat.stack_short) begin
            cmd.raise_en   = 1'b1;
            cmd.raise_code = ST_UNDERFLOW;
            state_next     = S_END;
          end else begin
            cmd.rd_top = 1'b1;
            state_next = S_FETCH_A;
          end
        end else if (stat.is_sep) begin
          state_next = S_END;
        end else begin
          cmd.raise_en   = 1'b1;
          cmd.raise_code = ST_BADCHAR;
          state_next     = S_END;
        end
      end
      S_FETCH_A: begin
        cmd.lat_b     = 1'b1;
        cmd.rd_second = 1'b1;
        state_next    = S_EXEC;
      end
      S_EXEC: begin
        if (stat.is_div_op) begin
          if (stat.divisor_zero) begin
            cmd.raise_en   = 1'b1;
            cmd.raise_code = ST_DIVZERO;
            state_next     = S_END;
          end else begin
            cmd.div_start = 1'b1;
            state_next    = S_DIV;
          end
        end else begin
          cmd.alu_exec = 1'b1;
          state_next   = S_WRITE;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.div_finish = 1'b1;
          state_next     = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.write_res = 1'b1;
        state_next    = S_END;
      end
      S_END: begin
        if (stat.last) begin
          if (!stat.err_set && stat.final_bad) begin
            cmd.raise_en   = 1'b1;
            cmd.raise_code = ST_COUNT;
          end
          cmd.rd_base = 1'b1;
          state_next  = S_FINISH;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_FINISH: begin
        // Wait for the result register to be free before handing over.
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/postfix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Division and modulo run on a divider that yields one quotient bit per cycle.
// A last item hands its result to the output register, and waits there while
// that register is still occupied. Reset clears the controller, counters and
// errors and sets max_length to 100; the stack RAM is not cleared.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator import pfe_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  pfe_in_if.sink           expr,
  pfe_out_if.source        result,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data
);

  cmd_t                cmd;
  stat_t               stat;
  logic                ready;
  logic [DATA_W-1:0]   value;
  logic [STATUS_W-1:0] status;
  logic                valid;

  assign expr.ready    = ready;
  assign result.valid  = valid;
  assign result.value  = value;
  assign result.status = status;

  pfe_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (expr.valid),
    .item_ready (ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  pfe_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .item_char   (expr.character),
    .item_last   (expr.last),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_ready   (result.ready),
    .out_valid   (valid),
    .out_value   (value),
    .out_status  (status)
  );

endmodule

FILE: design/pfe_checker.sv
// ----------------------------------------------------------------------------
// pfe_checker
// Port-level checks on the evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module pfe_checker import pfe_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [DATA_W-1:0]   out_value,
  input logic [STATUS_W-1:0] out_status
);

  // No result may be pending straight after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A failed expression reports a zero value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_status == STATUS_W'(ST_OK) || out_value == '0))
    else $error("non-zero value with error status");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_status <= STATUS_W'(ST_OVERFLOW)))
    else $error("status code out of range");

  // Each item passes through decode before the next is taken.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item taken while the previous one is still in work");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_value) && $stable(out_status)))
    else $error("stalled result changed");

endmodule

bind postfix_expression_evaluator pfe_checker u_pfe_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (expr.valid),
  .in_ready   (expr.ready),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .out_value  (result.value),
  .out_status (result.status)
);
